### src/zsc_pkg.sv
`default_nettype none

package zsc_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 128;

  localparam logic [31:0] KEY0_INIT = 32'h1234_5678;
  localparam logic [31:0] KEY1_INIT = 32'h2345_6789;
  localparam logic [31:0] KEY2_INIT = 32'h3456_7890;
  localparam logic [31:0] KEY1_MULT = 32'h0808_8405;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  localparam logic [1:0] CMD_RESTART  = 2'd0;
  localparam logic [1:0] CMD_PASSWORD = 2'd1;
  localparam logic [1:0] CMD_DATA     = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [1:0] {
    OP_RESTART  = 2'd0,
    OP_PASSWORD = 2'd1,
    OP_DATA     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_FETCH = 2'b01,
    ST_MIX   = 2'b10
  } bst_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } qentry_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
  } keys_t;

  localparam keys_t KEYS_INIT = '{k0: KEY0_INIT, k1: KEY1_INIT, k2: KEY2_INIT};

  function automatic logic [31:0] crc_byte(logic [31:0] v, logic [7:0] b);
    logic [31:0] r;
    r = {24'd0, v[7:0] ^ b};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r ^ {8'd0, v[31:8]};
  endfunction

  function automatic keys_t step_keys(keys_t k, logic [7:0] b);
    keys_t       n;
    logic [31:0] s;
    n.k0 = crc_byte(k.k0, b);
    s    = k.k1 + {24'd0, n.k0[7:0]};
    n.k1 = s * KEY1_MULT + 32'd1;
    n.k2 = crc_byte(k.k2, n.k1[31:24]);
    return n;
  endfunction

  function automatic logic [7:0] stream_byte(logic [31:0] k2);
    logic [15:0] t;
    logic [31:0] p;
    t = k2[15:0] | 16'd2;
    p = {16'd0, t} * {16'd0, t ^ 16'd1};
    return p[15:8];
  endfunction

endpackage

`default_nettype wire

### src/zip_stream_cipher_block128.sv
// Traditional PKZIP stream cipher over bytes, with the working keys reloaded
// from the base keys at the start of every block of BLOCK_BYTES data bytes.
// Restart and password transactions are handled in the fetch state and give
// no result; a data transaction forms the keystream byte from key 2 in the
// fetch state and steps the keys in the mix state, as each byte's keystream
// depends on the key update of the byte before it through two multiplies.
// A two-entry queue sits in front of the engine, so input transactions are
// taken while a result waits in the output register. The direction register
// should only be written while the block is idle.
`default_nettype none

module zip_stream_cipher_block128
  import zsc_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] command_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            block_last_o
);

  logic    direction_q;
  logic    avail;
  logic    pop;
  qentry_t entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
    end else if (cfg_we_i) begin
      direction_q <= cfg_wdata_i;
    end
  end

  zsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .stall_o     (in_stall_o),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .pop_i       (pop),
    .avail_o     (avail),
    .entry_o     (entry)
  );

  zsc_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .direction_i  (direction_q),
    .avail_i      (avail),
    .entry_i      (entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .block_last_o (block_last_o)
  );

endmodule

`default_nettype wire

### src/zsc_front.sv
`default_nettype none

module zsc_front
  import zsc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            stall_o,
  input  wire logic [1:0] command_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       pop_i,
  output logic            avail_o,
  output qentry_t         entry_o
);

  qentry_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                accept;
  logic                push;
  logic                pop;
  op_e                 op;
  logic                known;

  always_comb begin
    op    = OP_RESTART;
    known = 1'b1;
    case (command_i)
      CMD_RESTART:  op = OP_RESTART;
      CMD_PASSWORD: op = OP_PASSWORD;
      CMD_DATA:     op = OP_DATA;
      default:      known = 1'b0;
    endcase
  end

  assign stall_o = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign accept  = valid_i && !stall_o;
  assign push    = accept && known;
  assign avail_o = (cnt_q != '0);
  assign pop     = pop_i && avail_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{op: op, data: data_byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### src/zsc_back.sv
`default_nettype none

module zsc_back
  import zsc_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       direction_i,
  input  wire logic       avail_i,
  input  wire qentry_t    entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            block_last_o
);

  localparam int unsigned PosW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

  bst_e            state_q, state_d;
  keys_t           base_q, base_d;
  keys_t           work_q, work_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      ks_q, ks_d;
  logic [7:0]      byte_q, byte_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            last_q, last_d;
  keys_t           src;
  logic [7:0]      result;
  logic            out_free;
  logic            at_end;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_FETCH) && avail_i;
  assign src      = (pos_q == '0) ? base_q : work_q;
  assign result   = byte_q ^ ks_q;
  assign at_end   = (pos_q == PosW'(BLOCK_BYTES - 1));

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    work_d      = work_q;
    pos_d       = pos_q;
    ks_d        = ks_q;
    byte_d      = byte_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    case (state_q)
      ST_FETCH: begin
        if (avail_i) begin
          case (entry_i.op)
            OP_RESTART: begin
              base_d = KEYS_INIT;
              work_d = KEYS_INIT;
              pos_d  = '0;
            end
            OP_PASSWORD: begin
              base_d = step_keys(base_q, entry_i.data);
              pos_d  = '0;
            end
            OP_DATA: begin
              work_d  = src;
              ks_d    = stream_byte(src.k2);
              byte_d  = entry_i.data;
              state_d = ST_MIX;
            end
            default: ;
          endcase
        end
      end
      ST_MIX: begin
        if (out_free) begin
          work_d      = step_keys(work_q, direction_i ? result : byte_q);
          out_valid_d = 1'b1;
          out_byte_d  = result;
          last_d      = at_end;
          pos_d       = at_end ? '0 : pos_q + 1'b1;
          state_d     = ST_FETCH;
        end
      end
      default: state_d = ST_FETCH;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ks_q       <= ks_d;
    byte_q     <= byte_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FETCH;
      base_q      <= KEYS_INIT;
      work_q      <= KEYS_INIT;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      work_q      <= work_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign block_last_o = last_q;

endmodule

`default_nettype wire

### tb/zip_stream_cipher_block128_tb.sv
`timescale 1ns / 1ps

module zip_stream_cipher_block128_tb
  import zsc_pkg::*;
;

  localparam int unsigned BLOCK        = BLOCK_BYTES_DEF;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          REPORT_MAX   = 10;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] val;
  } txn_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } cipher_out_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
  } key_set_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic       cfg_wdata_i  = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [1:0] command_i    = CMD_RESTART;
  logic [7:0] data_byte_i  = 8'd0;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       block_last_o;

  txn_t        pending_txn_q[$];
  cipher_out_t expected_out_q[$];

  key_set_t base_ks;
  key_set_t work_ks;
  int       blk_pos;
  logic     decrypt_mode;

  int gap_left;
  int stall_left;
  int drv_rate;
  int mon_rate;
  int fail_count;
  int bytes_checked;
  int block_ends;
  int txn_accepted;
  int cycle_cnt;

  zip_stream_cipher_block128 #(
    .BLOCK_BYTES(BLOCK)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .block_last_o(block_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] crc32_shift(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic key_set_t advance_keys(key_set_t k, logic [7:0] b);
    key_set_t n;
    n.k0 = crc32_shift(k.k0, b);
    n.k1 = (k.k1 + {24'd0, n.k0[7:0]}) * KEY1_MULT + 32'd1;
    n.k2 = crc32_shift(k.k2, n.k1[31:24]);
    return n;
  endfunction

  function automatic logic [7:0] keystream_of(logic [31:0] k2);
    logic [31:0] t;
    logic [31:0] prod;
    t    = {16'd0, k2[15:0] | 16'd2};
    prod = t * (t ^ 32'd1);
    return prod[15:8];
  endfunction

  function automatic void predict_cipher(logic [1:0] cmd, logic [7:0] b);
    cipher_out_t r;
    key_set_t    init_ks;
    init_ks = '{k0: KEY0_INIT, k1: KEY1_INIT, k2: KEY2_INIT};
    case (cmd)
      CMD_RESTART: begin
        base_ks = init_ks;
        work_ks = init_ks;
        blk_pos = 0;
      end
      CMD_PASSWORD: begin
        base_ks = advance_keys(base_ks, b);
        blk_pos = 0;
      end
      CMD_DATA: begin
        if (blk_pos == 0) begin
          work_ks = base_ks;
        end
        r.out_byte = b ^ keystream_of(work_ks.k2);
        work_ks    = advance_keys(work_ks, decrypt_mode ? r.out_byte : b);
        blk_pos++;
        r.last = (blk_pos >= BLOCK);
        if (r.last) begin
          blk_pos = 0;
        end
        expected_out_q.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_txn(logic [1:0] cmd, logic [7:0] val);
    txn_t t;
    t.cmd = cmd;
    t.val = val;
    pending_txn_q.push_back(t);
  endfunction

  // Mostly well-formed sessions (restart, password, a run of data bytes), with
  // some long runs that cross block boundaries and some stray or unused commands.
  task automatic queue_random(int n);
    int done_cnt;
    int pick;
    int run;
    done_cnt = 0;
    while (done_cnt < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        push_txn(CMD_UNUSED, rand_byte());
        done_cnt++;
      end else if (pick < 9) begin
        push_txn(CMD_PASSWORD, rand_byte());
        done_cnt++;
      end else if (pick < 12) begin
        push_txn(CMD_RESTART, rand_byte());
        done_cnt++;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          push_txn(CMD_RESTART, rand_byte());
          done_cnt++;
          repeat ($urandom_range(1, 12)) begin
            push_txn(CMD_PASSWORD, rand_byte());
            done_cnt++;
          end
        end
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        if (run > n - done_cnt) begin
          run = n - done_cnt;
        end
        repeat (run) begin
          push_txn(CMD_DATA, rand_byte());
          done_cnt++;
        end
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_txn_q.size() != 0 || in_valid_i || expected_out_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_direction(logic v);
    @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    decrypt_mode  = v;
    @(negedge clk_i);
  endtask

  function automatic int pick_rate();
    int sel;
    sel = $urandom_range(0, 3);
    return (sel == 0) ? 0 : (sel == 1) ? 5 : (sel == 2) ? 12 : 25;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_cipher(command_i, data_byte_i);
        txn_accepted++;
      end
      if (in_valid_i && in_stall_o) begin
      end else if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_txn_q.size() != 0 && drv_rate > 0
                   && $urandom_range(0, 99) < drv_rate) begin
        gap_left   <= $urandom_range(0, 17);
        in_valid_i <= 1'b0;
      end else if (pending_txn_q.size() != 0) begin
        in_valid_i  <= 1'b1;
        command_i   <= pending_txn_q[0].cmd;
        data_byte_i <= pending_txn_q[0].val;
        void'(pending_txn_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_out_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("Unexpected transaction at %0t: out_byte=%02h block_last=%0b",
                     $realtime, out_byte_o, block_last_o);
          end
        end else begin
          if (expected_out_q[0].out_byte !== out_byte_o
              || expected_out_q[0].last !== block_last_o) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("Mismatch at %0t: expected out_byte=%02h block_last=%0b, got %02h %0b",
                       $realtime, expected_out_q[0].out_byte, expected_out_q[0].last,
                       out_byte_o, block_last_o);
            end
          end
          void'(expected_out_q.pop_front());
          bytes_checked++;
          if (block_last_o === 1'b1) begin
            block_ends++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (mon_rate > 0 && $urandom_range(0, 99) < mon_rate) begin
        stall_left  <= $urandom_range(0, 17);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d results outstanding.",
               CYCLE_LIMIT, expected_out_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    base_ks       = '{k0: KEY0_INIT, k1: KEY1_INIT, k2: KEY2_INIT};
    work_ks       = base_ks;
    blk_pos       = 0;
    decrypt_mode  = 1'b0;
    gap_left      = 0;
    stall_left    = 0;
    fail_count    = 0;
    bytes_checked = 0;
    block_ends    = 0;
    txn_accepted  = 0;
    cycle_cnt     = 0;
    drv_rate      = pick_rate();
    mon_rate      = pick_rate();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset keys and encryption first, then passwords, unused commands and restarts.
    push_txn(CMD_DATA, 8'h00);
    push_txn(CMD_DATA, 8'hFF);
    push_txn(CMD_UNUSED, 8'h5A);
    push_txn(CMD_PASSWORD, 8'h00);
    push_txn(CMD_PASSWORD, 8'hFF);
    push_txn(CMD_DATA, 8'h00);
    push_txn(CMD_DATA, 8'hFF);
    push_txn(CMD_DATA, 8'h80);
    push_txn(CMD_DATA, 8'h01);
    push_txn(CMD_RESTART, 8'hFF);
    push_txn(CMD_DATA, 8'h7F);
    push_txn(CMD_RESTART, 8'h00);
    push_txn(CMD_PASSWORD, 8'h70);
    push_txn(CMD_PASSWORD, 8'h31);
    push_txn(CMD_DATA, 8'hA5);
    push_txn(CMD_DATA, 8'h5A);
    push_txn(CMD_UNUSED, 8'hFF);
    push_txn(CMD_DATA, 8'h3C);
    push_txn(CMD_PASSWORD, 8'h80);
    push_txn(CMD_DATA, 8'hC3);
    push_txn(CMD_DATA, 8'h00);
    push_txn(CMD_RESTART, 8'h00);
    push_txn(CMD_DATA, 8'hFF);
    drain();

    // Direction changes fall between transactions, often inside a block.
    for (int ph = 0; ph < 4; ph++) begin
      set_direction(ph[0] ? 1'b0 : 1'b1);
      if (ph == 3) begin
        drv_rate = 0;
        mon_rate = 0;
        queue_random(200);
      end else begin
        drv_rate = pick_rate();
        mon_rate = pick_rate();
        queue_random(408);
      end
      drain();
    end

    fail_count += expected_out_q.size();
    $display("Checked %0d cipher bytes, %0d of them ending a block, from %0d transactions.",
             bytes_checked, block_ends, txn_accepted);
    $display("Both directions were exercised, with restarts, passwords and unused commands.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures.", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### zip_stream_cipher_block128.f
src/zsc_pkg.sv
src/zsc_front.sv
src/zsc_back.sv
src/zip_stream_cipher_block128.sv
tb/zip_stream_cipher_block128_tb.sv
